>>> rtl/core/tmc_pkg.sv
// ----------------------------------------------------------------------------
// tmc_pkg: shared types and constants of the tile map collision engine
// Sizes of the tile store, fixed field widths, command codes, controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none
package tmc_pkg;

  localparam int MAX_COLS       = 64;
  localparam int MAX_ROWS       = 64;
  localparam int MAX_PUSH_STEPS = 4096;

  localparam int DIM_MAX = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int IDX_W   = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
  localparam int QS_W    = IDX_W + 1;
  localparam int DEPTH   = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STEP_W  = $clog2(MAX_PUSH_STEPS + 1);

  localparam int CODE_W    = 16;
  localparam int DIM_W     = 7;
  localparam int TILE_W    = 9;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam int IN_POS_W  = 21;
  localparam int SIZE_W    = 14;
  localparam int POS_W     = 23;
  localparam int DIV_W     = POS_W - 4;
  localparam int DCNT_W    = $clog2(DIV_W);
  localparam int CMP_W     = (QS_W > DIM_W) ? QS_W : DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_COLS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_ROWS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 2'd3;

  localparam logic [2:0] CMD_GET      = 3'd0;
  localparam logic [2:0] CMD_SET      = 3'd1;
  localparam logic [2:0] CMD_OVERLAP  = 3'd2;
  localparam logic [2:0] CMD_PIXEL    = 3'd3;
  localparam logic [2:0] CMD_RESOLVE  = 3'd4;

  typedef enum logic [1:0] {
    PH_INIT,
    PH_X,
    PH_Y
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SET,
    S_CELL_RD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_BOUNDS,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RES,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic cell_rd;
    logic set_wr;
    logic div_go;
    logic scan_init;
    logic scan_rd;
    logic scan_next;
    logic ov_set;
    logic ov_val;
    logic set_hit;
    logic enter_x;
    logic enter_y;
    logic step;
    logic set_cap;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       div_done;
    logic       div_last;
    logic       empty;
    logic       solid;
    logic       scan_last;
    logic       ov;
    logic       ncap;
    logic       vsx_nz;
    phase_t     phase;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/tmc_ram.sv
// ----------------------------------------------------------------------------
// tmc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module tmc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/tmc_div.sv
// ----------------------------------------------------------------------------
// tmc_div: restoring divider, one quotient bit per cycle
// Divides an unsigned magnitude by a tile size; done pulses when finished.
// ----------------------------------------------------------------------------
`default_nettype none
module tmc_div
  import tmc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [TILE_W-1:0] divisor,
  output logic                   done,
  output logic      [DIV_W-1:0]  quot
);

  logic              run_r, run_nxt;
  logic              done_r, done_nxt;
  logic [DCNT_W-1:0] cnt_r;
  logic [TILE_W-1:0] rem_r;
  logic [DIV_W-1:0]  quo_r;
  logic [TILE_W-1:0] dvsr_r;
  logic [TILE_W:0]   trial;
  logic [TILE_W:0]   diff;
  logic              ge;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, dvsr_r};
  assign ge    = trial >= {1'b0, dvsr_r};

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      run_nxt = 1'b1;
    end else if (run_r && (cnt_r == DCNT_W'(DIV_W - 1))) begin
      run_nxt  = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r  <= '0;
      rem_r  <= '0;
      quo_r  <= dividend;
      dvsr_r <= divisor;
    end else if (run_r) begin
      cnt_r <= cnt_r + DCNT_W'(1);
      rem_r <= ge ? diff[TILE_W-1:0] : trial[TILE_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = quo_r;

endmodule
`default_nettype wire

>>> rtl/core/tmc_dp.sv
// ----------------------------------------------------------------------------
// tmc_dp: datapath of the tile map collision engine
// Configuration, captured command word, tile store, divider, scan counters,
// push positions and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module tmc_dp
  import tmc_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ctrl_cmd_t                  cmd,
  output dp_stat_t                        stat,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_W-1:0]           cfg_wdata,
  input  wire logic [2:0]                 in_command,
  input  wire logic signed [7:0]          in_cell_col,
  input  wire logic signed [7:0]          in_cell_row,
  input  wire logic signed [CODE_W-1:0]   in_write_code,
  input  wire logic signed [IN_POS_W-1:0] in_pos_x,
  input  wire logic signed [IN_POS_W-1:0] in_pos_y,
  input  wire logic [SIZE_W-1:0]          in_rect_w,
  input  wire logic [SIZE_W-1:0]          in_rect_h,
  input  wire logic signed [1:0]          in_vel_x_sign,
  input  wire logic                       in_falling,
  output logic                            out_valid,
  output logic signed [CODE_W-1:0]        out_read_code,
  output logic                            out_cell_on_map,
  output logic                            out_hit,
  output logic signed [IN_POS_W-1:0]      out_new_x,
  output logic signed [IN_POS_W-1:0]      out_new_y,
  output logic                            out_stop_x,
  output logic                            out_stop_y,
  output logic                            out_push_capped
);

  localparam logic signed [POS_W-1:0] STEP_Q4 = POS_W'(16);
  localparam logic signed [POS_W-1:0] POS_HI  = POS_W'((2 ** (IN_POS_W - 1)) - 1);
  localparam logic signed [POS_W-1:0] POS_LO  = ~POS_HI;

  // Configuration registers.
  logic [DIM_W-1:0]  map_cols_r, map_rows_r;
  logic [TILE_W-1:0] tile_w_r, tile_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_cols_r <= DIM_W'(1);
      map_rows_r <= DIM_W'(1);
      tile_w_r   <= TILE_W'(16);
      tile_h_r   <= TILE_W'(16);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAP_COLS:    map_cols_r <= cfg_wdata[DIM_W-1:0];
        REG_MAP_ROWS:    map_rows_r <= cfg_wdata[DIM_W-1:0];
        REG_TILE_WIDTH:  tile_w_r   <= cfg_wdata[TILE_W-1:0];
        REG_TILE_HEIGHT: tile_h_r   <= cfg_wdata[TILE_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0]  cols_eff, rows_eff;
  logic [TILE_W-1:0] tw_eff, th_eff;

  assign cols_eff = (int'(map_cols_r) > MAX_COLS) ? DIM_W'(MAX_COLS) : map_cols_r;
  assign rows_eff = (int'(map_rows_r) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : map_rows_r;
  assign tw_eff   = (tile_w_r == '0) ? TILE_W'(1) : tile_w_r;
  assign th_eff   = (tile_h_r == '0) ? TILE_W'(1) : tile_h_r;

  // Captured command word.
  logic [2:0]               cmd_r;
  logic signed [7:0]        col_r, row_r;
  logic [CODE_W-1:0]        code_r;
  logic [SIZE_W-1:0]        w_r, h_r;
  logic signed [1:0]        vsx_r;
  logic                     fall_r;
  logic signed [POS_W-1:0]  bx_r, by_r;

  // Push loop state.
  phase_t            phase_r;
  logic [STEP_W-1:0] n_r;
  logic              ov_r, hit_r, sx_r, sy_r, cap_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_INIT;
    end else if (cmd.load) begin
      phase_r <= PH_INIT;
    end else if (cmd.enter_x) begin
      phase_r <= PH_X;
    end else if (cmd.enter_y) begin
      phase_r <= PH_Y;
    end
  end

  logic signed [POS_W-1:0] dx, dy;
  assign dx = (vsx_r == 2'sb01) ? -STEP_Q4 : STEP_Q4;
  assign dy = fall_r ? -STEP_Q4 : STEP_Q4;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_command;
      col_r  <= in_cell_col;
      row_r  <= in_cell_row;
      code_r <= in_write_code;
      w_r    <= in_rect_w;
      h_r    <= in_rect_h;
      vsx_r  <= in_vel_x_sign;
      fall_r <= in_falling;
      bx_r   <= POS_W'(in_pos_x);
      by_r   <= POS_W'(in_pos_y);
      hit_r  <= 1'b0;
      sx_r   <= 1'b0;
      sy_r   <= 1'b0;
      cap_r  <= 1'b0;
    end else begin
      if (cmd.step) begin
        if (phase_r == PH_X) begin
          bx_r <= bx_r + dx;
        end else begin
          by_r <= by_r + dy;
        end
      end
      if (cmd.set_hit) hit_r <= ov_r;
      if (cmd.enter_x) sx_r <= 1'b1;
      if (cmd.enter_y) sy_r <= 1'b1;
      if (cmd.set_cap) cap_r <= 1'b1;
    end
    if (cmd.enter_x || cmd.enter_y) begin
      n_r <= '0;
    end else if (cmd.step) begin
      n_r <= n_r + STEP_W'(1);
    end
    if (cmd.ov_set) ov_r <= cmd.ov_val;
  end

  // Division of the four rectangle edges (or the point) by the tile size.
  logic [1:0]              sel_r;
  logic [QS_W-1:0]         q_r   [4];
  logic                    neg_r [4];
  logic signed [POS_W-1:0] base, edge_v, dv;
  logic [POS_W-1:0]        mag;
  logic                    div_done;
  logic [DIV_W-1:0]        quot;
  logic [QS_W-1:0]         q_sat;

  assign base   = sel_r[0] ? by_r : bx_r;
  assign edge_v = base + POS_W'(sel_r[0] ? h_r : w_r) - STEP_Q4;
  assign dv     = sel_r[1] ? edge_v : base;
  assign mag    = dv[POS_W-1] ? POS_W'(-dv) : POS_W'(dv);

  tmc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_go),
    .dividend (mag[POS_W-1:4]),
    .divisor  (sel_r[0] ? th_eff : tw_eff),
    .done     (div_done),
    .quot     (quot)
  );

  assign q_sat = (|quot[DIV_W-1:QS_W]) ? {QS_W{1'b1}} : quot[QS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= '0;
    end else if (cmd.load || cmd.step) begin
      sel_r <= '0;
    end else if (div_done) begin
      sel_r <= sel_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (div_done) begin
      q_r[sel_r]   <= q_sat;
      neg_r[sel_r] <= dv[POS_W-1];
    end
  end

  // Covered column and row ranges, clipped to the map.
  logic             c0_over, c1_under, r0_over, r1_under, lo_gt_hi;
  logic [IDX_W-1:0] c0, c1, r0, r1;

  function automatic logic lt_dim(input logic [QS_W-1:0] q, input logic [DIM_W-1:0] d);
    return CMP_W'(q) < CMP_W'(d);
  endfunction

  assign c0_over  = !neg_r[0] && !lt_dim(q_r[0], cols_eff);
  assign r0_over  = !neg_r[1] && !lt_dim(q_r[1], rows_eff);
  assign c1_under = (neg_r[2] && (q_r[2] != '0)) || (cols_eff == '0);
  assign r1_under = (neg_r[3] && (q_r[3] != '0)) || (rows_eff == '0);
  assign c0 = neg_r[0] ? '0 : q_r[0][IDX_W-1:0];
  assign r0 = neg_r[1] ? '0 : q_r[1][IDX_W-1:0];
  assign c1 = lt_dim(q_r[2], cols_eff) ? q_r[2][IDX_W-1:0] : IDX_W'(cols_eff - DIM_W'(1));
  assign r1 = lt_dim(q_r[3], rows_eff) ? q_r[3][IDX_W-1:0] : IDX_W'(rows_eff - DIM_W'(1));
  assign lo_gt_hi = (c0 > c1) || (r0 > r1);

  // Scan counters.
  logic [IDX_W-1:0] sc_r, sr_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      sc_r <= c0;
      sr_r <= r0;
    end else if (cmd.scan_next) begin
      if (sc_r == c1) begin
        sc_r <= c0;
        sr_r <= sr_r + IDX_W'(1);
      end else begin
        sc_r <= sc_r + IDX_W'(1);
      end
    end
  end

  // Single cell addressed by get, set or tile_at_pixel.
  logic             cur_on;
  logic [IDX_W-1:0] cur_c, cur_r;

  always_comb begin
    if (cmd_r == CMD_PIXEL) begin
      cur_on = (!neg_r[0] || (q_r[0] == '0)) && lt_dim(q_r[0], cols_eff) &&
               (!neg_r[1] || (q_r[1] == '0)) && lt_dim(q_r[1], rows_eff);
      cur_c  = q_r[0][IDX_W-1:0];
      cur_r  = q_r[1][IDX_W-1:0];
    end else begin
      cur_on = !col_r[7] && !row_r[7] &&
               (CMP_W'(col_r[6:0]) < CMP_W'(cols_eff)) &&
               (CMP_W'(row_r[6:0]) < CMP_W'(rows_eff));
      cur_c  = IDX_W'(col_r[6:0]);
      cur_r  = IDX_W'(row_r[6:0]);
    end
  end

  // Tile store.
  logic [IDX_W-1:0]       a_c, a_r;
  logic [ADDR_W-1:0]      addr;
  logic [IDX_W+DIM_W-1:0] prod;
  logic [CODE_W-1:0]      rdata;

  assign a_c  = (cmd.scan_rd) ? sc_r : cur_c;
  assign a_r  = (cmd.scan_rd) ? sr_r : cur_r;
  assign prod = a_r * cols_eff;
  assign addr = ADDR_W'(prod) + ADDR_W'(a_c);

  tmc_ram #(
    .WIDTH (CODE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.set_wr && cur_on),
    .waddr (addr),
    .wdata (code_r),
    .re    (cmd.scan_rd || (cmd.cell_rd && cur_on)),
    .raddr (addr),
    .rdata (rdata)
  );

  // Status toward the controller.
  always_comb begin
    stat.cmd       = cmd_r;
    stat.div_done  = div_done;
    stat.div_last  = (cmd_r == CMD_PIXEL) ? (sel_r == 2'd1) : (sel_r == 2'd3);
    stat.empty     = c0_over || r0_over || c1_under || r1_under || lo_gt_hi;
    stat.solid     = !rdata[CODE_W-1] && (rdata != '0);
    stat.scan_last = (sc_r == c1) && (sr_r == r1);
    stat.ov        = ov_r;
    stat.ncap      = n_r >= STEP_W'(MAX_PUSH_STEPS);
    stat.vsx_nz    = vsx_r != 2'sb00;
    stat.phase     = phase_r;
  end

  // Result registers.
  logic signed [POS_W-1:0] sat_x, sat_y;
  logic                    valid_r;

  assign sat_x = (bx_r > POS_HI) ? POS_HI : ((bx_r < POS_LO) ? POS_LO : bx_r);
  assign sat_y = (by_r > POS_HI) ? POS_HI : ((by_r < POS_LO) ? POS_LO : by_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_read_code   <= '0;
      out_cell_on_map <= 1'b0;
      out_hit         <= 1'b0;
      out_new_x       <= '0;
      out_new_y       <= '0;
      out_stop_x      <= 1'b0;
      out_stop_y      <= 1'b0;
      out_push_capped <= 1'b0;
      case (cmd_r)
        CMD_GET, CMD_PIXEL: begin
          out_read_code   <= cur_on ? rdata : '1;
          out_cell_on_map <= cur_on;
        end
        CMD_SET: begin
          out_cell_on_map <= cur_on;
        end
        CMD_OVERLAP: begin
          out_hit <= ov_r;
        end
        CMD_RESOLVE: begin
          out_hit         <= hit_r;
          out_new_x       <= IN_POS_W'(sat_x);
          out_new_y       <= IN_POS_W'(sat_y);
          out_stop_x      <= sx_r;
          out_stop_y      <= sy_r;
          out_push_capped <= cap_r;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = valid_r;

endmodule
`default_nettype wire

>>> rtl/core/tmc_ctrl.sv
// ----------------------------------------------------------------------------
// tmc_ctrl: command sequencer of the tile map collision engine
// Walks each command through the tile access, divisions, tile scans and push steps it needs.
// ----------------------------------------------------------------------------
`default_nettype none
module tmc_ctrl
  import tmc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire dp_stat_t stat,
  output ctrl_cmd_t     cmd
);

  state_t state_r, state_nxt;
  state_t ov_end;

  assign ov_end = (stat.cmd == CMD_RESOLVE) ? S_RES : S_DONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat.cmd)
          CMD_GET:                          state_nxt = S_CELL_RD;
          CMD_SET:                          state_nxt = S_SET;
          CMD_OVERLAP, CMD_PIXEL, CMD_RESOLVE: state_nxt = S_DIV_GO;
          default:                          state_nxt = S_DONE;
        endcase
      end
      S_SET:      state_nxt = S_DONE;
      S_CELL_RD:  state_nxt = S_DONE;
      S_DIV_GO:   state_nxt = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          if (!stat.div_last) begin
            state_nxt = S_DIV_GO;
          end else if (stat.cmd == CMD_PIXEL) begin
            state_nxt = S_CELL_RD;
          end else begin
            state_nxt = S_BOUNDS;
          end
        end
      end
      S_BOUNDS:   state_nxt = stat.empty ? ov_end : S_SCAN_RD;
      S_SCAN_RD:  state_nxt = S_SCAN_CHK;
      S_SCAN_CHK: state_nxt = (stat.solid || stat.scan_last) ? ov_end : S_SCAN_RD;
      S_RES: begin
        case (stat.phase)
          PH_INIT: state_nxt = (stat.ov) ? S_RES : S_DONE;
          PH_X: begin
            if (!stat.ov)       state_nxt = S_DONE;
            else if (stat.ncap) state_nxt = S_RES;
            else                state_nxt = S_DIV_GO;
          end
          default: begin
            state_nxt = (stat.ov && !stat.ncap) ? S_DIV_GO : S_DONE;
          end
        endcase
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = state_r != S_IDLE;
    case (state_r)
      S_IDLE:     cmd.load = start;
      S_SET:      cmd.set_wr = 1'b1;
      S_CELL_RD:  cmd.cell_rd = 1'b1;
      S_DIV_GO:   cmd.div_go = 1'b1;
      S_BOUNDS: begin
        if (stat.empty) begin
          cmd.ov_set = 1'b1;
        end else begin
          cmd.scan_init = 1'b1;
        end
      end
      S_SCAN_RD:  cmd.scan_rd = 1'b1;
      S_SCAN_CHK: begin
        if (stat.solid) begin
          cmd.ov_set = 1'b1;
          cmd.ov_val = 1'b1;
        end else if (stat.scan_last) begin
          cmd.ov_set = 1'b1;
        end else begin
          cmd.scan_next = 1'b1;
        end
      end
      S_RES: begin
        case (stat.phase)
          PH_INIT: begin
            cmd.set_hit = 1'b1;
            if (stat.ov && stat.vsx_nz) begin
              cmd.enter_x = 1'b1;
            end else if (stat.ov) begin
              cmd.enter_y = 1'b1;
            end
          end
          PH_X: begin
            if (stat.ov && stat.ncap) begin
              cmd.set_cap = 1'b1;
              cmd.enter_y = 1'b1;
            end else if (stat.ov) begin
              cmd.step = 1'b1;
            end
          end
          default: begin
            if (stat.ov && stat.ncap) begin
              cmd.set_cap = 1'b1;
            end else if (stat.ov) begin
              cmd.step = 1'b1;
            end
          end
        endcase
      end
      S_DONE:  cmd.finish = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/core/tile_map_collision_engine.sv
// ----------------------------------------------------------------------------
// tile_map_collision_engine: tile map store with rectangle collision and push
// Serves get, set, overlap, tile_at_pixel and resolve on one tile map.
// ----------------------------------------------------------------------------
// get and set pass dispatch, a tile store access and the done state before
// out_valid; tile_at_pixel divides the pixel position by the tile size per
// axis and reads that cell; overlap divides every edge on the serial divider
// (one quotient bit per cycle), then reads covered tiles on the single store
// read port until one is solid; resolve repeats one overlap per pixel step,
// up to MAX_PUSH_STEPS steps per axis. One command is in flight at a time;
// the result word is shown for one cycle and the receiver cannot stall it.
// Reset (synchronous, rst_n low) returns the sequencer to idle and the
// configuration to one column, one row and 16 by 16 pixel tiles; the tile
// store keeps no reset and must be written before it is read.
// ----------------------------------------------------------------------------
`default_nettype none
module tile_map_collision_engine
  import tmc_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_W-1:0]           cfg_wdata,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [2:0]                 in_command,
  input  wire logic signed [7:0]          in_cell_col,
  input  wire logic signed [7:0]          in_cell_row,
  input  wire logic signed [CODE_W-1:0]   in_write_code,
  input  wire logic signed [IN_POS_W-1:0] in_pos_x,
  input  wire logic signed [IN_POS_W-1:0] in_pos_y,
  input  wire logic [SIZE_W-1:0]          in_rect_w,
  input  wire logic [SIZE_W-1:0]          in_rect_h,
  input  wire logic signed [1:0]          in_vel_x_sign,
  input  wire logic                       in_falling,
  output logic                            out_valid,
  output logic signed [CODE_W-1:0]        out_read_code,
  output logic                            out_cell_on_map,
  output logic                            out_hit,
  output logic signed [IN_POS_W-1:0]      out_new_x,
  output logic signed [IN_POS_W-1:0]      out_new_y,
  output logic                            out_stop_x,
  output logic                            out_stop_y,
  output logic                            out_push_capped
);

  // The controller sequences each command; the datapath holds every value.
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  tmc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  tmc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_command      (in_command),
    .in_cell_col     (in_cell_col),
    .in_cell_row     (in_cell_row),
    .in_write_code   (in_write_code),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_rect_w       (in_rect_w),
    .in_rect_h       (in_rect_h),
    .in_vel_x_sign   (in_vel_x_sign),
    .in_falling      (in_falling),
    .out_valid       (out_valid),
    .out_read_code   (out_read_code),
    .out_cell_on_map (out_cell_on_map),
    .out_hit         (out_hit),
    .out_new_x       (out_new_x),
    .out_new_y       (out_new_y),
    .out_stop_x      (out_stop_x),
    .out_stop_y      (out_stop_y),
    .out_push_capped (out_push_capped)
  );

  // A result word only follows a cycle in which a command was in flight.
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without a command in flight");

  // An accepted command always occupies the engine in the next cycle.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not make the engine busy");

  // The push cap can only be reached inside a push loop.
  a_cap_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_push_capped) |-> (out_stop_x || out_stop_y))
    else $error("push cap reported without a push");

endmodule
`default_nettype wire

>>> sim/tile_map_collision_engine_test.sv
// ----------------------------------------------------------------------------
// tile_map_collision_engine_test: self-checking regression of the tile map engine
// A driver feeds command words from a queue, and the accepted words are run
// through a behavioral copy of the map, its geometry and the push loops. A
// monitor compares every result word field by field against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module tile_map_collision_engine_test;
  import tmc_pkg::*;

  localparam int  STORE_N    = MAX_COLS * MAX_ROWS;
  localparam int  FILL_ROWS  = 4;
  localparam int  IDLE_LIMIT = 2000000;
  localparam int  TAIL_WAIT  = 64;
  localparam int  RAND_ITEMS = 480;
  localparam longint PIX     = 16;  // one pixel in Q.4 units
  localparam longint POS_LO  = -1048576;
  localparam longint POS_HI  = 1048575;

  // One command word as it is put on the input ports.
  typedef struct {
    logic [2:0]               command;
    logic signed [7:0]        cell_col;
    logic signed [7:0]        cell_row;
    logic signed [CODE_W-1:0] write_code;
    logic signed [20:0]       pos_x;
    logic signed [20:0]       pos_y;
    logic [SIZE_W-1:0]        rect_w;
    logic [SIZE_W-1:0]        rect_h;
    logic signed [1:0]        vel_x_sign;
    logic                     falling;
  } cmd_word_t;

  // One result word as the engine should present it.
  typedef struct {
    logic signed [CODE_W-1:0] read_code;
    logic                     cell_on_map;
    logic                     hit;
    logic signed [20:0]       new_x;
    logic signed [20:0]       new_y;
    logic                     stop_x;
    logic                     stop_y;
    logic                     push_capped;
  } result_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic [2:0] in_command = '0;
  logic signed [7:0] in_cell_col = '0;
  logic signed [7:0] in_cell_row = '0;
  logic signed [CODE_W-1:0] in_write_code = '0;
  logic signed [20:0] in_pos_x = '0;
  logic signed [20:0] in_pos_y = '0;
  logic [SIZE_W-1:0] in_rect_w = '0;
  logic [SIZE_W-1:0] in_rect_h = '0;
  logic signed [1:0] in_vel_x_sign = '0;
  logic in_falling = 1'b0;
  logic out_valid;
  logic signed [CODE_W-1:0] out_read_code;
  logic out_cell_on_map;
  logic out_hit;
  logic signed [20:0] out_new_x;
  logic signed [20:0] out_new_y;
  logic out_stop_x;
  logic out_stop_y;
  logic out_push_capped;

  tile_map_collision_engine dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .start(start), .busy(busy),
    .in_command(in_command), .in_cell_col(in_cell_col), .in_cell_row(in_cell_row),
    .in_write_code(in_write_code), .in_pos_x(in_pos_x), .in_pos_y(in_pos_y),
    .in_rect_w(in_rect_w), .in_rect_h(in_rect_h),
    .in_vel_x_sign(in_vel_x_sign), .in_falling(in_falling),
    .out_valid(out_valid), .out_read_code(out_read_code),
    .out_cell_on_map(out_cell_on_map), .out_hit(out_hit),
    .out_new_x(out_new_x), .out_new_y(out_new_y),
    .out_stop_x(out_stop_x), .out_stop_y(out_stop_y),
    .out_push_capped(out_push_capped)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Shadow copy of the engine: the tile codes and the four registers.
  logic [CODE_W-1:0] shadow_map [STORE_N];
  int unsigned map_cols_r = 1;
  int unsigned map_rows_r = 1;
  int unsigned tile_w_r = 16;
  int unsigned tile_h_r = 16;

  cmd_word_t    cmd_q[$];      // words waiting for the driver
  result_word_t expected_q[$]; // predicted results in issue order
  int  gap_pct = 0;            // chance in percent that the sender idles a cycle
  int  errors = 0;
  logic took = 1'b0;           // a word was taken at the last rising edge
  int  idle_cycles = 0;

  function automatic longint cols_eff();
    return (map_cols_r > MAX_COLS) ? MAX_COLS : map_cols_r;
  endfunction

  function automatic longint rows_eff();
    return (map_rows_r > MAX_ROWS) ? MAX_ROWS : map_rows_r;
  endfunction

  // Tile sizes in Q.4 units; a zero size behaves as one pixel.
  function automatic longint tw_units();
    return longint'((tile_w_r == 0) ? 1 : tile_w_r) * PIX;
  endfunction

  function automatic longint th_units();
    return longint'((tile_h_r == 0) ? 1 : tile_h_r) * PIX;
  endfunction

  function automatic bit cell_is_on_map(longint c, longint r);
    return c >= 0 && r >= 0 && c < cols_eff() && r < rows_eff();
  endfunction

  function automatic longint tile_code(longint c, longint r);
    longint idx;
    idx = r * cols_eff() + c;
    if (idx < 0 || idx >= STORE_N) return 0;
    return longint'($signed(shadow_map[idx]));
  endfunction

  // True when the rectangle covers any on-map tile with a positive code.
  // Division truncates toward zero, as the SystemVerilog operator does.
  function automatic bit rect_touches_solid(longint x, longint y, longint w, longint h);
    longint c0, c1, r0, r1;
    c0 = x / tw_units();
    r0 = y / th_units();
    c1 = (x + w - PIX) / tw_units();
    r1 = (y + h - PIX) / th_units();
    if (c0 < 0) c0 = 0;
    if (r0 < 0) r0 = 0;
    if (c1 > cols_eff() - 1) c1 = cols_eff() - 1;
    if (r1 > rows_eff() - 1) r1 = rows_eff() - 1;
    for (longint r = r0; r <= r1; r++)
      for (longint c = c0; c <= c1; c++)
        if (tile_code(c, r) > 0) return 1'b1;
    return 1'b0;
  endfunction

  function automatic longint clamp_pos(longint v);
    return (v < POS_LO) ? POS_LO : ((v > POS_HI) ? POS_HI : v);
  endfunction

  // Works out the result of one accepted word and applies any tile write.
  function automatic result_word_t run_command(cmd_word_t w);
    result_word_t res;
    longint col, row, bx, by, rw, rh, dir, idx;
    int n;
    res = '{default: '0};
    col = w.cell_col;
    row = w.cell_row;
    rw = longint'(w.rect_w);
    rh = longint'(w.rect_h);
    case (w.command)
      CMD_GET, CMD_PIXEL: begin
        if (w.command == CMD_PIXEL) begin
          col = longint'(w.pos_x) / tw_units();
          row = longint'(w.pos_y) / th_units();
        end
        res.cell_on_map = cell_is_on_map(col, row);
        res.read_code = res.cell_on_map ? CODE_W'(tile_code(col, row)) : -16'sd1;
      end
      CMD_SET: begin
        res.cell_on_map = cell_is_on_map(col, row);
        if (res.cell_on_map) begin
          idx = row * cols_eff() + col;
          if (idx >= 0 && idx < STORE_N) shadow_map[idx] = w.write_code;
        end
      end
      CMD_OVERLAP: begin
        res.hit = rect_touches_solid(w.pos_x, w.pos_y, rw, rh);
      end
      CMD_RESOLVE: begin
        bx = w.pos_x;
        by = w.pos_y;
        res.hit = rect_touches_solid(bx, by, rw, rh);
        // The X push runs against the velocity, then Y up when falling.
        if (w.vel_x_sign != 0 && res.hit) begin
          dir = (w.vel_x_sign > 0) ? -PIX : PIX;
          n = 0;
          while (rect_touches_solid(bx, by, rw, rh)) begin
            if (n >= MAX_PUSH_STEPS) begin
              res.push_capped = 1'b1;
              break;
            end
            bx += dir;
            n++;
          end
          res.stop_x = 1'b1;
        end
        if (rect_touches_solid(bx, by, rw, rh)) begin
          dir = w.falling ? -PIX : PIX;
          n = 0;
          while (rect_touches_solid(bx, by, rw, rh)) begin
            if (n >= MAX_PUSH_STEPS) begin
              res.push_capped = 1'b1;
              break;
            end
            by += dir;
            n++;
          end
          res.stop_y = 1'b1;
        end
        res.new_x = 21'(clamp_pos(bx));
        res.new_y = 21'(clamp_pos(by));
      end
      default: ;  // unused codes change nothing and return zeros
    endcase
    return res;
  endfunction

  // Driver: inputs change on the falling edge only. A new word is loaded
  // when the line is free or the last word was just taken.
  always @(negedge clk) begin
    if (rst_n && (!start || took)) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        cmd_word_t w;
        w = cmd_q.pop_front();
        in_command    <= w.command;
        in_cell_col   <= w.cell_col;
        in_cell_row   <= w.cell_row;
        in_write_code <= w.write_code;
        in_pos_x      <= w.pos_x;
        in_pos_y      <= w.pos_y;
        in_rect_w     <= w.rect_w;
        in_rect_h     <= w.rect_h;
        in_vel_x_sign <= w.vel_x_sign;
        in_falling    <= w.falling;
        start         <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predicts on acceptance, checks each strobed result word, and
  // keeps the watchdog on cycles in which nothing moves.
  always @(posedge clk) begin
    cmd_word_t w;
    result_word_t exp_w;
    took <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      w = '{in_command, in_cell_col, in_cell_row, in_write_code, in_pos_x, in_pos_y,
            in_rect_w, in_rect_h, in_vel_x_sign, in_falling};
      expected_q.push_back(run_command(w));
    end
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result word, read_code %0d", $time, out_read_code);
        errors++;
      end else begin
        exp_w = expected_q.pop_front();
        if (out_read_code !== exp_w.read_code) begin
          $display("%0t: read_code expected %0d actual %0d", $time, exp_w.read_code,
                   out_read_code);
          errors++;
        end
        if (out_cell_on_map !== exp_w.cell_on_map) begin
          $display("%0t: cell_on_map expected %0b actual %0b", $time, exp_w.cell_on_map,
                   out_cell_on_map);
          errors++;
        end
        if (out_hit !== exp_w.hit) begin
          $display("%0t: hit expected %0b actual %0b", $time, exp_w.hit, out_hit);
          errors++;
        end
        if (out_new_x !== exp_w.new_x) begin
          $display("%0t: new_x expected %0d actual %0d", $time, exp_w.new_x, out_new_x);
          errors++;
        end
        if (out_new_y !== exp_w.new_y) begin
          $display("%0t: new_y expected %0d actual %0d", $time, exp_w.new_y, out_new_y);
          errors++;
        end
        if (out_stop_x !== exp_w.stop_x) begin
          $display("%0t: stop_x expected %0b actual %0b", $time, exp_w.stop_x, out_stop_x);
          errors++;
        end
        if (out_stop_y !== exp_w.stop_y) begin
          $display("%0t: stop_y expected %0b actual %0b", $time, exp_w.stop_y, out_stop_y);
          errors++;
        end
        if (out_push_capped !== exp_w.push_capped) begin
          $display("%0t: push_capped expected %0b actual %0b", $time, exp_w.push_capped,
                   out_push_capped);
          errors++;
        end
      end
    end
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("tile_map_collision_engine regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic cmd_word_t make_word(logic [2:0] cmd, longint col, longint row,
                                          longint code, longint x, longint y,
                                          longint w, longint h, longint vx, bit fall);
    cmd_word_t c;
    c.command = cmd;
    c.cell_col = 8'(col);
    c.cell_row = 8'(row);
    c.write_code = 16'(code);
    c.pos_x = 21'(x);
    c.pos_y = 21'(y);
    c.rect_w = 14'(w);
    c.rect_h = 14'(h);
    c.vel_x_sign = 2'(vx);
    c.falling = fall;
    return c;
  endfunction

  // Random word shaped by the current map. Positions mostly land on or near
  // the map; resolve bodies stay small so that the push loops end quickly.
  function automatic cmd_word_t random_word(bit allow_resolve);
    cmd_word_t c;
    longint span_x, span_y;
    int pick;
    span_x = cols_eff() * tw_units() + 1;
    span_y = rows_eff() * th_units() + 1;
    c.write_code = 16'($urandom);
    c.vel_x_sign = 2'($urandom_range(2) - 1);
    c.falling = $urandom_range(1);
    pick = $urandom_range(99);
    if (pick < 20) c.command = CMD_GET;
    else if (pick < 40) c.command = CMD_SET;
    else if (pick < 60) c.command = CMD_OVERLAP;
    else if (pick < 77) c.command = CMD_PIXEL;
    else if (pick < 97) c.command = allow_resolve ? CMD_RESOLVE : CMD_OVERLAP;
    else c.command = 3'(5 + $urandom_range(2));
    if ($urandom_range(9) == 0) begin
      c.cell_col = 8'($urandom);
      c.cell_row = 8'($urandom);
    end else begin
      c.cell_col = 8'(longint'($urandom_range(cols_eff() + 3)) - 2);
      c.cell_row = 8'(longint'($urandom_range(rows_eff() + 3)) - 2);
    end
    if ($urandom_range(9) == 0) begin
      c.pos_x = 21'($urandom);
      c.pos_y = 21'($urandom);
    end else begin
      c.pos_x = 21'(longint'($urandom_range(32'(span_x + 2 * tw_units()))) - tw_units());
      c.pos_y = 21'(longint'($urandom_range(32'(span_y + 2 * th_units()))) - th_units());
    end
    if (c.command == CMD_RESOLVE) begin
      c.rect_w = 14'($urandom_range(32'(2 * tw_units())));
      c.rect_h = 14'($urandom_range(32'(2 * th_units())));
    end else if ($urandom_range(7) == 0) begin
      c.rect_w = 14'($urandom);
      c.rect_h = 14'($urandom);
    end else begin
      c.rect_w = 14'($urandom_range(32'(3 * tw_units() < 16383 ? 3 * tw_units() : 16383)));
      c.rect_h = 14'($urandom_range(32'(3 * th_units() < 16383 ? 3 * th_units() : 16383)));
    end
    return c;
  endfunction

  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(val);
    case (idx)
      REG_MAP_COLS:   map_cols_r = val & 32'h7F;
      REG_MAP_ROWS:   map_rows_r = val & 32'h7F;
      REG_TILE_WIDTH: tile_w_r = val & 32'h1FF;
      default:        tile_h_r = val & 32'h1FF;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_map(int unsigned cols, int unsigned rows, int unsigned tw,
                         int unsigned th);
    reg_write(REG_MAP_COLS, cols);
    reg_write(REG_MAP_ROWS, rows);
    reg_write(REG_TILE_WIDTH, tw);
    reg_write(REG_TILE_HEIGHT, th);
  endtask

  // Holds the sender back until every queued word has been answered. Every
  // command produces a result, so a short margin is enough afterwards.
  task automatic drain();
    while (cmd_q.size() != 0 || start || expected_q.size() != 0 || busy)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // No setting below covers more than MAX_COLS * FILL_ROWS cells.
  int unsigned map_sets [8][4] = '{
    '{8, 8, 16, 16}, '{0, 5, 4, 4}, '{127, 4, 0, 0}, '{64, 4, 1, 1},
    '{3, 64, 511, 2}, '{64, 2, 7, 511}, '{1, 1, 16, 16}, '{16, 0, 8, 8}
  };
  int gap_modes [4] = '{0, 78, 0, 8};

  initial begin
    int per_phase;
    bit small_tiles;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every entry that any map setting below can reach is written first, so
    // no later read can hit an unwritten cell. Row 0 is all solid so the
    // capped push can run along it.
    set_map(64, FILL_ROWS, 16, 16);
    for (int r = 0; r < FILL_ROWS; r++)
      for (int c = 0; c < MAX_COLS; c++)
        cmd_q.push_back(make_word(CMD_SET, c, r,
          (r == 0) ? $urandom_range(32767, 1) :
          ($urandom_range(99) < 30 ? $urandom_range(32767, 1) : -$urandom_range(40)),
          0, 0, 0, 0, 0, 0));
    drain();

    // Directed words: field extremes, every command and the corner cases.
    cmd_q.push_back(make_word(CMD_GET, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_word(CMD_GET, 63, 3, 0, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_word(CMD_GET, 63, 63, 0, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_word(CMD_GET, -128, 127, 0, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_word(CMD_GET, 127, -128, 0, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_word(CMD_SET, 5, 2, 32767, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_word(CMD_GET, 5, 2, 0, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_word(CMD_SET, 6, 2, -32768, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_word(CMD_GET, 6, 2, 0, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_word(CMD_SET, -1, 3, 77, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_word(CMD_SET, 0, 64, 77, 0, 0, 0, 0, 0, 0));
    cmd_q.push_back(make_word(CMD_OVERLAP, 0, 0, 0, POS_LO, POS_LO, 16383, 16383, 0, 0));
    cmd_q.push_back(make_word(CMD_OVERLAP, 0, 0, 0, POS_HI, POS_HI, 16383, 16383, 0, 0));
    cmd_q.push_back(make_word(CMD_OVERLAP, 0, 0, 0, 1280, 512, 0, 0, 0, 0));
    cmd_q.push_back(make_word(CMD_PIXEL, 0, 0, 0, -1, -1, 0, 0, 0, 0));
    cmd_q.push_back(make_word(CMD_PIXEL, 0, 0, 0, POS_HI, 600, 0, 0, 0, 0));
    cmd_q.push_back(make_word(CMD_PIXEL, 0, 0, 0, -4096, 1000, 0, 0, 0, 0));
    cmd_q.push_back(make_word(CMD_RESOLVE, 0, 0, 0, 1280, 512, 256, 256, 1, 1));
    cmd_q.push_back(make_word(CMD_RESOLVE, 0, 0, 0, 1290, 520, 300, 200, -1, 0));
    cmd_q.push_back(make_word(CMD_RESOLVE, 0, 0, 0, 1296, 512, 256, 256, 0, 1));
    cmd_q.push_back(make_word(CMD_RESOLVE, 0, 0, 0, 100, 2, 16, 16, 1, 0));
    cmd_q.push_back(make_word(3'd5, 3, 3, 5, 100, 100, 16, 16, 1, 1));
    cmd_q.push_back(make_word(3'd6, 3, 3, 5, 100, 100, 16, 16, 1, 1));
    cmd_q.push_back(make_word(3'd7, 3, 3, 5, 100, 100, 16, 16, 1, 1));
    drain();

    // Capped push: a body deep inside a solid strip 16384 pixels long is
    // moved 4096 pixels left and is still inside, then drops off the map.
    set_map(64, 1, 256, 1);
    cmd_q.push_back(make_word(CMD_RESOLVE, 0, 0, 0, 128000, 0, 16, 16, 1, 0));
    drain();
    for (int c = 0; c < MAX_COLS; c++)
      cmd_q.push_back(make_word(CMD_SET, c, 0, 0,
        $urandom_range(99) < 30 ? $urandom_range(32767, 1) : 0, 0, 0, 0, 0, 0));
    foreach (cmd_q[i]) cmd_q[i].write_code = cmd_q[i].pos_x[15:0];
    foreach (cmd_q[i]) cmd_q[i].pos_x = '0;
    drain();

    // Random part: every map setting is run twice, each time under the same idling mode.
    per_phase = RAND_ITEMS / 16;
    for (int p = 0; p < 16; p++) begin
      set_map(map_sets[p % 8][0], map_sets[p % 8][1], map_sets[p % 8][2],
              map_sets[p % 8][3]);
      gap_pct = gap_modes[(p / 2) % 4];
      small_tiles = tw_units() <= 32 * PIX && th_units() <= 32 * PIX;
      for (int i = 0; i < per_phase; i++) begin
        cmd_q.push_back(random_word(small_tiles));
        // Hold the sender once mid-phase until the engine has caught up.
        if (i == per_phase / 2) drain();
      end
      drain();
    end

    repeat (TAIL_WAIT) @(negedge clk);
    if (errors == 0) begin
      $display("tile_map_collision_engine regression: pass");
    end else begin
      $display("tile_map_collision_engine regression: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/tmc_pkg.sv
rtl/core/tmc_ram.sv
rtl/core/tmc_div.sv
rtl/core/tmc_dp.sv
rtl/core/tmc_ctrl.sv
rtl/core/tile_map_collision_engine.sv
sim/tile_map_collision_engine_test.sv
